@@ rtl/sbb_pkg.sv @@
// shared types and constants for the sphere box boundary bounce block
package sbb_pkg;

    localparam int WORD_W      = 32;
    localparam int RAD_W       = 31;
    localparam int REST_W      = 17;
    localparam int REST_BITS   = 16;
    localparam int NUM_AXES    = 3;
    localparam int BOUNCE_W    = 2;
    localparam int CNT_W       = 3;
    localparam int MAX_BOUNCES = 6;
    localparam int LANE_STAGES = 2;
    localparam int NUM_STAGES  = LANE_STAGES + MAX_BOUNCES;
    localparam int IN_DATA_W   = 9 * WORD_W + RAD_W + REST_W;
    localparam int OUT_DATA_W  = 9 * WORD_W;
    localparam int CFG_IDX_W   = 3;

    typedef logic signed [WORD_W-1:0] word_t;

    // register map of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WALL_MIN_X = 3'd0,
        CFG_WALL_MIN_Y = 3'd1,
        CFG_WALL_MIN_Z = 3'd2,
        CFG_WALL_MAX_X = 3'd3,
        CFG_WALL_MAX_Y = 3'd4,
        CFG_WALL_MAX_Z = 3'd5
    } cfg_idx_t;

    // full body state carried down the damping stages
    typedef struct packed {
        word_t [NUM_AXES-1:0] pos;
        word_t [NUM_AXES-1:0] vel;
        word_t [NUM_AXES-1:0] spin;
    } body_t;

    // stage loads driven into each axis lane
    typedef struct packed {
        logic load1;
        logic load2;
    } lane_ctrl_t;

    // what one axis lane hands to the merge
    typedef struct packed {
        word_t                pos;
        word_t                vel;
        logic [BOUNCE_W-1:0]  bounces;
    } lane_out_t;

endpackage

@@ rtl/sbb_axis_lane.sv @@
// one axis of the wall check: min wall stage, max wall stage, velocity bounce
module sbb_axis_lane (
    input  logic                         clk,
    input  sbb_pkg::lane_ctrl_t          ctrl,
    input  sbb_pkg::word_t               pos,
    input  sbb_pkg::word_t               vel,
    input  sbb_pkg::word_t               wall_lo,
    input  sbb_pkg::word_t               wall_hi,
    input  logic [sbb_pkg::RAD_W-1:0]    radius,
    input  logic [sbb_pkg::REST_W-1:0]   rest,
    input  logic                         is_static,
    output sbb_pkg::lane_out_t           result
);
    import sbb_pkg::*;

    localparam int EXT_W    = WORD_W + 2;
    localparam int PROD1_W  = WORD_W + REST_W;
    localparam int PROD2_W  = WORD_W - 1 + REST_W;
    localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    // saturate a wide signed value to one word
    function automatic word_t sat32(input logic signed [EXT_W-1:0] v);
        word_t res;
        if ((&v[EXT_W-1:WORD_W-1]) || !(|v[EXT_W-1:WORD_W-1])) begin
            res = v[WORD_W-1:0];
        end
        else if (v[EXT_W-1]) begin
            res = WORD_MIN;
        end
        else begin
            res = WORD_MAX;
        end
        return res;
    endfunction

    // min wall check on the incoming item
    logic signed [EXT_W-1:0] pos_ext;
    logic signed [EXT_W-1:0] rad_ext;
    logic signed [EXT_W-1:0] lo_ext;
    logic                    hit_lo;
    logic                    bounce_lo;
    logic [WORD_W-1:0]       vel_mag;
    logic [PROD1_W-1:0]      prod_lo;
    word_t                   pos1_next;

    assign pos_ext   = {{(EXT_W-WORD_W){pos[WORD_W-1]}}, pos};
    assign rad_ext   = {{(EXT_W-RAD_W){1'b0}}, radius};
    assign lo_ext    = {{(EXT_W-WORD_W){wall_lo[WORD_W-1]}}, wall_lo};
    assign hit_lo    = !is_static && ((pos_ext - rad_ext) < lo_ext);
    assign pos1_next = hit_lo ? sat32(lo_ext + rad_ext) : pos;
    assign bounce_lo = hit_lo && vel[WORD_W-1];
    assign vel_mag   = ~vel + 1'b1;
    assign prod_lo   = PROD1_W'(vel_mag) * PROD1_W'(rest);

    word_t                   pos1_reg;
    word_t                   vel1_reg;
    logic                    bounce_lo1_reg;
    logic [PROD1_W-1:0]      prod_lo_reg;
    logic [RAD_W-1:0]        rad1_reg;
    logic [REST_W-1:0]       rest1_reg;
    logic                    static1_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load1)
        begin
            pos1_reg       <= pos1_next;
            vel1_reg       <= vel;
            bounce_lo1_reg <= bounce_lo;
            prod_lo_reg    <= prod_lo;
            rad1_reg       <= radius;
            rest1_reg      <= rest;
            static1_reg    <= is_static;
        end
    end

    // min wall velocity result, then max wall check
    logic [PROD1_W-REST_BITS-1:0] q_lo;
    word_t                   vel_up;
    word_t                   vel1;
    logic signed [EXT_W-1:0] pos1_ext;
    logic signed [EXT_W-1:0] rad1_ext;
    logic signed [EXT_W-1:0] hi_ext;
    logic                    hit_hi;
    logic                    bounce_hi;
    logic [PROD2_W-1:0]      prod_hi;
    word_t                   pos2_next;

    assign q_lo      = prod_lo_reg[PROD1_W-1:REST_BITS];
    assign vel_up    = (q_lo > (PROD1_W-REST_BITS)'(WORD_MAX)) ? WORD_MAX
                                                              : q_lo[WORD_W-1:0];
    assign vel1      = bounce_lo1_reg ? vel_up : vel1_reg;
    assign pos1_ext  = {{(EXT_W-WORD_W){pos1_reg[WORD_W-1]}}, pos1_reg};
    assign rad1_ext  = {{(EXT_W-RAD_W){1'b0}}, rad1_reg};
    assign hi_ext    = {{(EXT_W-WORD_W){wall_hi[WORD_W-1]}}, wall_hi};
    assign hit_hi    = !static1_reg && ((pos1_ext + rad1_ext) > hi_ext);
    assign pos2_next = hit_hi ? sat32(hi_ext - rad1_ext) : pos1_reg;
    assign bounce_hi = hit_hi && !vel1[WORD_W-1] && (vel1 != '0);
    assign prod_hi   = PROD2_W'(vel1[WORD_W-2:0]) * PROD2_W'(rest1_reg);

    word_t                   pos2_reg;
    word_t                   vel2_reg;
    logic                    bounce_lo2_reg;
    logic                    bounce_hi_reg;
    logic [PROD2_W-1:0]      prod_hi_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load2)
        begin
            pos2_reg       <= pos2_next;
            vel2_reg       <= vel1;
            bounce_lo2_reg <= bounce_lo1_reg;
            bounce_hi_reg  <= bounce_hi;
            prod_hi_reg    <= prod_hi;
        end
    end

    // max wall velocity result, saturating at the negative end
    logic [WORD_W-1:0] q_hi;
    word_t             vel_dn;

    assign q_hi   = prod_hi_reg[PROD2_W-1:REST_BITS];
    assign vel_dn = q_hi[WORD_W-1] ? WORD_MIN : word_t'(~q_hi + 1'b1);

    assign result.pos     = pos2_reg;
    assign result.vel     = bounce_hi_reg ? vel_dn : vel2_reg;
    assign result.bounces = {1'b0, bounce_lo2_reg} + {1'b0, bounce_hi_reg};

endmodule

@@ rtl/sbb_spin_damp.sv @@
// one spin damping stage: scales all three spin components by 0.98 if a bounce is left
module sbb_spin_damp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        load,
    input  sbb_pkg::body_t              body_in,
    input  logic [sbb_pkg::CNT_W-1:0]   cnt_in,
    output sbb_pkg::body_t              body_out,
    output logic [sbb_pkg::CNT_W-1:0]   cnt_out
);
    import sbb_pkg::*;

    localparam int PROD_W = WORD_W + FRAC_BITS;
    localparam logic [FRAC_BITS-1:0] DampQ =
        FRAC_BITS'(((64'd98 << FRAC_BITS) + 64'd50) / 64'd100);

    body_t             body_next;
    logic [CNT_W-1:0]  cnt_next;
    logic              apply;

    // per component magnitude multiply, truncate toward zero
    always_comb
    begin
        logic [WORD_W-1:0] mag;
        logic [PROD_W-1:0] prod;
        logic [WORD_W-1:0] q;
        body_next = body_in;
        apply     = (cnt_in != '0);
        cnt_next  = apply ? cnt_in - 1'b1 : cnt_in;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            mag  = body_in.spin[i][WORD_W-1] ? ~body_in.spin[i] + 1'b1 : body_in.spin[i];
            prod = PROD_W'(mag) * PROD_W'(DampQ);
            q    = prod[PROD_W-1:FRAC_BITS];
            if (apply)
            begin
                body_next.spin[i] = body_in.spin[i][WORD_W-1] ? ~q + 1'b1 : q;
            end
        end
    end

    body_t             body_reg;
    logic [CNT_W-1:0]  cnt_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            body_reg <= body_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign body_out = body_reg;
    assign cnt_out  = cnt_reg;

endmodule

@@ rtl/sphere_box_boundary_bounce.sv @@
// top level: wall registers, axis lanes, merge and spin damping pipeline
// Sphere against an axis-aligned box. Takes one body per cycle when the
// output is not stalled and returns the corrected body through these stages:
// two stages in each of the three axis lanes (min wall, then max wall,
// each with its own velocity multiplier) and six spin damping stages, one
// multiplier stage per possible bounce. Every stage holds its item only
// while the stage after it is full, so bubbles close up and the input is
// taken whenever any stage has room. Walls are written through the
// configuration port, which is always ready; write them only while no body
// is in flight. A static body passes unchanged.
module sphere_box_boundary_bounce #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // slave side
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // pos_x_in, pos_y_in, pos_z_in, vel_x_in, vel_y_in, vel_z_in,
    // spin_x_in, spin_y_in, spin_z_in, body_radius, bounce_factor
    input  logic [sbb_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // is_static
    input  logic                              s_axis_tuser,
    // master side
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // pos_x_out, pos_y_out, pos_z_out, vel_x_out, vel_y_out, vel_z_out,
    // spin_x_out, spin_y_out, spin_z_out
    output logic [sbb_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sbb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  sbb_pkg::word_t                    cfg_data
);
    import sbb_pkg::*;

    localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    // wall registers
    word_t [NUM_AXES-1:0] wall_min_reg;
    word_t [NUM_AXES-1:0] wall_max_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wall_min_reg <= {NUM_AXES{WORD_MIN}};
            wall_max_reg <= {NUM_AXES{WORD_MAX}};
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_WALL_MIN_X: wall_min_reg[0] <= cfg_data;
                CFG_WALL_MIN_Y: wall_min_reg[1] <= cfg_data;
                CFG_WALL_MIN_Z: wall_min_reg[2] <= cfg_data;
                CFG_WALL_MAX_X: wall_max_reg[0] <= cfg_data;
                CFG_WALL_MAX_Y: wall_max_reg[1] <= cfg_data;
                CFG_WALL_MAX_Z: wall_max_reg[2] <= cfg_data;
                default:        ;
            endcase
        end
    end

    // pipeline occupancy and stall chain
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES:0]   ready;
    logic [NUM_STAGES-1:0] valid_in;
    logic [NUM_STAGES-1:0] load;

    assign valid_in = {valid_reg[NUM_STAGES-2:0], s_axis_tvalid};

    always_comb
    begin
        ready[NUM_STAGES] = m_axis_tready;
        for (int i = NUM_STAGES - 1; i >= 0; i--)
        begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
        for (int i = 0; i < NUM_STAGES; i++)
        begin
            load[i]       = ready[i] && valid_in[i];
            valid_next[i] = ready[i] ? valid_in[i] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_axis_tready = ready[0];
    assign m_axis_tvalid = valid_reg[NUM_STAGES-1];

    // input unpacking
    word_t [NUM_AXES-1:0]  pos_in;
    word_t [NUM_AXES-1:0]  vel_in;
    word_t [NUM_AXES-1:0]  spin_in;
    logic [RAD_W-1:0]      body_radius;
    logic [REST_W-1:0]     bounce_factor;

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            pos_in[i]  = s_axis_tdata[i*WORD_W +: WORD_W];
            vel_in[i]  = s_axis_tdata[(NUM_AXES+i)*WORD_W +: WORD_W];
            spin_in[i] = s_axis_tdata[(2*NUM_AXES+i)*WORD_W +: WORD_W];
        end
    end

    assign body_radius   = s_axis_tdata[3*NUM_AXES*WORD_W +: RAD_W];
    assign bounce_factor = s_axis_tdata[3*NUM_AXES*WORD_W+RAD_W +: REST_W];

    // spin rides alongside the lane stages
    word_t [NUM_AXES-1:0] spin1_reg;
    word_t [NUM_AXES-1:0] spin2_reg;

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            spin1_reg <= spin_in;
        end
        if (load[1])
        begin
            spin2_reg <= spin1_reg;
        end
    end

    // axis lanes
    lane_ctrl_t lane_ctrl;
    lane_out_t  lane_res [NUM_AXES];

    assign lane_ctrl.load1 = load[0];
    assign lane_ctrl.load2 = load[1];

    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_lane
        sbb_axis_lane u_lane (
            .clk       (clk),
            .ctrl      (lane_ctrl),
            .pos       (pos_in[a]),
            .vel       (vel_in[a]),
            .wall_lo   (wall_min_reg[a]),
            .wall_hi   (wall_max_reg[a]),
            .radius    (body_radius),
            .rest      (bounce_factor),
            .is_static (s_axis_tuser),
            .result    (lane_res[a])
        );
    end

    // merge the lanes and total the bounces
    body_t             dbody [MAX_BOUNCES+1];
    logic [CNT_W-1:0]  dcnt  [MAX_BOUNCES+1];

    always_comb
    begin
        dcnt[0] = '0;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            dbody[0].pos[a] = lane_res[a].pos;
            dbody[0].vel[a] = lane_res[a].vel;
            dcnt[0]         = dcnt[0] + CNT_W'(lane_res[a].bounces);
        end
        dbody[0].spin = spin2_reg;
    end

    // spin damping, one stage per possible bounce
    for (genvar j = 0; j < MAX_BOUNCES; j++)
    begin : g_damp
        sbb_spin_damp #(
            .FRAC_BITS (FRAC_BITS)
        ) u_damp (
            .clk      (clk),
            .load     (load[LANE_STAGES+j]),
            .body_in  (dbody[j]),
            .cnt_in   (dcnt[j]),
            .body_out (dbody[j+1]),
            .cnt_out  (dcnt[j+1])
        );
    end

    // output packing
    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            m_axis_tdata[i*WORD_W +: WORD_W]              = dbody[MAX_BOUNCES].pos[i];
            m_axis_tdata[(NUM_AXES+i)*WORD_W +: WORD_W]   = dbody[MAX_BOUNCES].vel[i];
            m_axis_tdata[(2*NUM_AXES+i)*WORD_W +: WORD_W] = dbody[MAX_BOUNCES].spin[i];
        end
    end

`ifndef SYNTHESIS
    // a taken item always lands in the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> valid_reg[0])
        else $error("accepted item lost at first stage");

    // an open output never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output is open");

    // every bounce has been applied by the time the item leaves
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (dcnt[MAX_BOUNCES] == '0))
        else $error("spin damping left undone at output");
`endif

endmodule

@@ tb/testbench.sv @@
// testbench for the sphere box boundary bounce block: random and directed bodies
`timescale 1ns / 1ps

module testbench;
    import sbb_pkg::*;

    localparam int     FRAC_BITS    = 16;
    localparam longint ONE          = longint'(1) << FRAC_BITS;
    localparam longint DAMP_Q       = ((longint'(98) << FRAC_BITS) + 50) / 100;
    localparam longint WMIN         = -2147483647 - 1;
    localparam longint WMAX         = 2147483647;
    localparam longint RAD_MAX      = 2147483647;
    localparam longint BNC_MAX      = 131071;
    localparam longint UNITY        = 65536;
    localparam int     DRAIN_CYCLES = 16;
    localparam int     CYCLE_LIMIT  = 200000;

    // indexes outside the register map, writes to them must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_7 = 3'd7;

    typedef struct packed {
        logic                 is_static;
        logic [IN_DATA_W-1:0] data;
    } body_item_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    word_t                 cfg_data;

    // wall registers as the block should hold them
    longint wall_lo [3] = '{WMIN, WMIN, WMIN};
    longint wall_hi [3] = '{WMAX, WMAX, WMAX};

    body_item_t             pending_bodies [$];
    logic [OUT_DATA_W-1:0]  corrected_bodies [$];
    body_item_t             next_item;
    logic [OUT_DATA_W-1:0]  body_want;

    int  n_queued   = 0;
    int  n_sent     = 0;
    int  n_checked  = 0;
    int  n_errors   = 0;
    int  n_settings = 0;
    int  n_cycles   = 0;
    int  src_wait   = 0;
    int  sink_wait  = 0;
    int  sink_draw  = 0;
    bit  src_idle_on  = 1'b1;
    bit  sink_idle_on = 1'b1;

    string field_names [9] = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z",
                               "spin_x", "spin_y", "spin_z"};

    sphere_box_boundary_bounce #(
        .FRAC_BITS (FRAC_BITS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // saturate to the signed 32-bit range
    function automatic longint clip32(input longint x);
        if (x > WMAX)
            return WMAX;
        if (x < WMIN)
            return WMIN;
        return x;
    endfunction

    // a * m / 2^sh, truncated toward zero, then saturated
    function automatic longint mul_frac(input longint a, input longint m, input int sh);
        longint mag;
        mag = (a < 0) ? -a : a;
        mag = (mag * m) >>> sh;
        return clip32((a < 0) ? -mag : mag);
    endfunction

    // corrected body for one input item, walls checked x min first, z max last
    function automatic logic [OUT_DATA_W-1:0] bounce_body(input logic [IN_DATA_W-1:0] d,
                                                          input logic stat);
        longint pos [3];
        longint vel [3];
        longint spin [3];
        longint rad;
        longint rest;
        word_t  w;
        logic [OUT_DATA_W-1:0] r;
        for (int i = 0; i < 3; i++)
        begin
            w = d[WORD_W*i +: WORD_W];
            pos[i] = w;
            w = d[WORD_W*(3+i) +: WORD_W];
            vel[i] = w;
            w = d[WORD_W*(6+i) +: WORD_W];
            spin[i] = w;
        end
        rad  = longint'(d[9*WORD_W +: RAD_W]);
        rest = longint'(d[9*WORD_W+RAD_W +: REST_W]);
        if (!stat)
        begin
            for (int a = 0; a < 3; a++)
            begin
                // low wall
                if (pos[a] - rad < wall_lo[a])
                begin
                    pos[a] = clip32(wall_lo[a] + rad);
                    if (vel[a] < 0)
                    begin
                        vel[a] = mul_frac(-vel[a], rest, REST_BITS);
                        for (int k = 0; k < 3; k++)
                            spin[k] = mul_frac(spin[k], DAMP_Q, FRAC_BITS);
                    end
                end
                // high wall sees the low wall correction
                if (pos[a] + rad > wall_hi[a])
                begin
                    pos[a] = clip32(wall_hi[a] - rad);
                    if (vel[a] > 0)
                    begin
                        vel[a] = mul_frac(-vel[a], rest, REST_BITS);
                        for (int k = 0; k < 3; k++)
                            spin[k] = mul_frac(spin[k], DAMP_Q, FRAC_BITS);
                    end
                end
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            r[WORD_W*i +: WORD_W]     = word_t'(pos[i]);
            r[WORD_W*(3+i) +: WORD_W] = word_t'(vel[i]);
            r[WORD_W*(6+i) +: WORD_W] = word_t'(spin[i]);
        end
        return r;
    endfunction

    // pack one body and queue it for the driver
    task automatic add_body(input longint px, input longint py, input longint pz,
                            input longint vx, input longint vy, input longint vz,
                            input longint sx, input longint sy, input longint sz,
                            input longint rad, input longint bnc, input logic stat);
        body_item_t item;
        item.data = {REST_W'(bnc), RAD_W'(rad), word_t'(sz), word_t'(sy), word_t'(sx),
                     word_t'(vz), word_t'(vy), word_t'(vx), word_t'(pz), word_t'(py),
                     word_t'(px)};
        item.is_static = stat;
        pending_bodies.push_back(item);
        n_queued++;
    endtask

    // random body, mostly placed against the current walls
    task automatic add_random_bodies(input int count);
        longint p [3];
        longint v [3];
        longint s [3];
        longint rad;
        longint bnc;
        longint delta;
        repeat (count)
        begin
            case ($urandom_range(0, 9))
                0: rad = longint'($urandom) & RAD_MAX;
                1: rad = 0;
                default: rad = longint'($urandom_range(0, 4 * ONE));
            endcase
            for (int i = 0; i < 3; i++)
            begin
                delta = longint'($urandom_range(0, 2 * ONE)) - ONE;
                case ($urandom_range(0, 5))
                    0: p[i] = longint'($urandom);
                    1, 2: p[i] = clip32(wall_lo[i] + rad + delta);
                    3, 4: p[i] = clip32(wall_hi[i] - rad + delta);
                    default: p[i] = delta * 8;
                endcase
                if ($urandom_range(0, 7) == 0)
                    v[i] = longint'($urandom);
                else
                    v[i] = longint'($urandom_range(0, 8 * ONE)) - 4 * ONE;
                if ($urandom_range(0, 3) == 0)
                    s[i] = longint'($urandom);
                else
                    s[i] = longint'($urandom_range(0, 4 * ONE)) - 2 * ONE;
            end
            case ($urandom_range(0, 7))
                0: bnc = longint'($urandom_range(65537, 131071));
                1: bnc = UNITY;
                2: bnc = 0;
                default: bnc = longint'($urandom_range(0, 65536));
            endcase
            add_body(p[0], p[1], p[2], v[0], v[1], v[2], s[0], s[1], s[2], rad, bnc,
                     $urandom_range(0, 9) == 0);
        end
    endtask

    // wait until every queued body has come back, then let the pipeline settle
    task automatic wait_idle();
        do
            @(posedge clk);
        while (n_sent != n_queued || corrected_bodies.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one register write, entered at a rising edge, leaves valid high
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input word_t val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_WALL_MIN_X: wall_lo[0] = val;
            CFG_WALL_MIN_Y: wall_lo[1] = val;
            CFG_WALL_MIN_Z: wall_lo[2] = val;
            CFG_WALL_MAX_X: wall_hi[0] = val;
            CFG_WALL_MAX_Y: wall_hi[1] = val;
            CFG_WALL_MAX_Z: wall_hi[2] = val;
            default: ;
        endcase
    endtask

    task automatic set_walls(input longint lx, input longint ly, input longint lz,
                             input longint hx, input longint hy, input longint hz,
                             input bit junk);
        write_reg(CFG_WALL_MIN_X, word_t'(lx));
        write_reg(CFG_WALL_MIN_Y, word_t'(ly));
        write_reg(CFG_WALL_MIN_Z, word_t'(lz));
        write_reg(CFG_WALL_MAX_X, word_t'(hx));
        write_reg(CFG_WALL_MAX_Y, word_t'(hy));
        write_reg(CFG_WALL_MAX_Z, word_t'(hz));
        if (junk)
        begin
            write_reg(CFG_UNMAPPED_6, word_t'($urandom));
            write_reg(CFG_UNMAPPED_7, word_t'(32'hffff_ffff));
        end
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // random box: mostly a sane box near the origin, sometimes anything
    task automatic set_random_walls();
        longint lo [3];
        longint hi [3];
        for (int i = 0; i < 3; i++)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                lo[i] = longint'($urandom);
                hi[i] = longint'($urandom);
            end
            else
            begin
                lo[i] = -longint'($urandom_range(0, 64)) * ONE -
                        longint'($urandom_range(0, 65535));
                hi[i] = lo[i] + longint'($urandom_range(0, 128)) * ONE;
            end
        end
        set_walls(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], 1'b0);
    endtask

    // driver: predicts on every accepted item, then presents the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
            src_wait      <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                corrected_bodies.push_back(bounce_body(s_axis_tdata, s_axis_tuser));
                n_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (src_wait != 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    src_wait      <= src_wait - 1;
                end
                else if (pending_bodies.size() != 0)
                begin
                    next_item = pending_bodies.pop_front();
                    s_axis_tdata  <= next_item.data;
                    s_axis_tuser  <= next_item.is_static;
                    s_axis_tvalid <= 1'b1;
                    if ($urandom_range(0, 39) == 0)
                        src_idle_on = ($urandom_range(0, 2) != 0);
                    src_wait <= src_idle_on ? int'($urandom_range(0, 3)) : 0;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: compares each result with the oldest prediction, random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_wait     <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (corrected_bodies.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("result with no body pending: %h", m_axis_tdata);
                end
                else
                begin
                    body_want = corrected_bodies.pop_front();
                    for (int f = 0; f < 9; f++)
                    begin
                        if (m_axis_tdata[WORD_W*f +: WORD_W] !== body_want[WORD_W*f +: WORD_W])
                        begin
                            n_errors++;
                            if (n_errors <= 10)
                                $display("mismatch on result %0d, %s: expected %h, got %h",
                                         n_checked, field_names[f],
                                         body_want[WORD_W*f +: WORD_W],
                                         m_axis_tdata[WORD_W*f +: WORD_W]);
                        end
                    end
                    n_checked++;
                end
                if ($urandom_range(0, 39) == 0)
                    sink_idle_on = ($urandom_range(0, 2) != 0);
                sink_draw = sink_idle_on ? int'($urandom_range(0, 3)) : 0;
                if (sink_draw == 0)
                    m_axis_tready <= 1'b1;
                else
                begin
                    m_axis_tready <= 1'b0;
                    sink_wait     <= sink_draw - 1;
                end
            end
            else if (sink_wait != 0)
            begin
                m_axis_tready <= 1'b0;
                sink_wait     <= sink_wait - 1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", n_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // stimulus: reset, then one phase per wall setting
    initial
    begin
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_WALL_MIN_X;
        cfg_data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // open walls from reset: only bodies at the range edges can touch them
        add_body(WMIN, 0, 0, WMIN, 0, 0, ONE, ONE, ONE, RAD_MAX, UNITY, 1'b0);
        add_body(WMAX, WMAX, WMAX, WMAX, 0, WMAX, WMIN, 0, WMAX, 1, BNC_MAX, 1'b0);
        add_random_bodies(100);
        wait_idle();

        // box of +-10 on every axis
        set_walls(-10 * ONE, -10 * ONE, -10 * ONE, 10 * ONE, 10 * ONE, 10 * ONE, 1'b0);
        // body well inside
        add_body(0, 0, 0, 0, 0, 0, ONE, -ONE, 0, ONE, UNITY, 1'b0);
        // static body far outside
        add_body(50 * ONE, -50 * ONE, 0, 3 * ONE, -3 * ONE, ONE, ONE, ONE, ONE,
                 2 * ONE, UNITY, 1'b1);
        // x min hit moving in, half restitution
        add_body(-10 * ONE, 0, 0, -2 * ONE, 0, 0, 4 * ONE, -4 * ONE, ONE, ONE,
                 UNITY / 2, 1'b0);
        // x max hit moving away: clamp only
        add_body(10 * ONE, 0, 0, -ONE, 0, 0, ONE, ONE, ONE, ONE, UNITY, 1'b0);
        // x max hit moving in
        add_body(10 * ONE, 0, 0, ONE, 0, 0, ONE, ONE, ONE, ONE, UNITY, 1'b0);
        // y min hit moving away
        add_body(0, -10 * ONE, 0, 0, ONE, 0, ONE, ONE, ONE, ONE, UNITY, 1'b0);
        // y max hit, largest speed and restitution: product saturates
        add_body(0, 10 * ONE, 0, 0, WMAX, 0, ONE, ONE, ONE, ONE, BNC_MAX, 1'b0);
        // z min hit with the most negative speed
        add_body(0, 0, -10 * ONE, 0, 0, WMIN, ONE, ONE, ONE, ONE, UNITY, 1'b0);
        add_body(0, 0, -10 * ONE, 0, 0, WMIN, ONE, ONE, ONE, ONE, BNC_MAX, 1'b0);
        // z max hit, no restitution
        add_body(0, 0, 10 * ONE, 0, 0, 2 * ONE, ONE, ONE, ONE, ONE, 0, 1'b0);
        // corner: three bounces damp the spin three times
        add_body(-11 * ONE, -11 * ONE, -11 * ONE, -ONE, -ONE, -ONE, WMIN, WMAX, -1,
                 ONE, UNITY, 1'b0);
        // just touching is no penetration
        add_body(-9 * ONE, 9 * ONE, 0, -ONE, ONE, 0, ONE, ONE, ONE, ONE, UNITY, 1'b0);
        // one step past the wall
        add_body(-9 * ONE - 1, 0, 0, -1, 0, 0, ONE, ONE, ONE, ONE, UNITY, 1'b0);
        // zero radius on the walls
        add_body(-10 * ONE, 10 * ONE, 0, -ONE, ONE, 0, ONE, ONE, ONE, 0, UNITY, 1'b0);
        // wider than the box: both walls fire
        add_body(0, 0, 0, ONE, -ONE, 0, ONE, ONE, ONE, 15 * ONE, UNITY, 1'b0);
        // every field at its top and bottom
        add_body(WMAX, WMAX, WMAX, WMIN, WMIN, WMIN, WMAX, WMAX, WMAX, RAD_MAX, BNC_MAX, 1'b0);
        add_body(WMIN, WMIN, WMIN, WMAX, WMAX, WMAX, WMIN, WMIN, WMIN, RAD_MAX, 0, 1'b0);
        add_body(WMAX, WMAX, WMAX, WMIN, WMIN, WMIN, WMAX, WMAX, WMAX, RAD_MAX, BNC_MAX, 1'b1);
        add_random_bodies(250);
        wait_idle();

        // uneven small box, z box entirely negative
        set_walls(-3 * ONE, 0, -100 * ONE, 5 * ONE, ONE, -50 * ONE, 1'b0);
        add_random_bodies(250);
        wait_idle();

        // crossed and collapsed walls: the max wall decides last
        set_walls(4 * ONE, 0, ONE, -4 * ONE, 0, -ONE, 1'b0);
        add_random_bodies(200);
        wait_idle();

        // walls at opposite extremes, clamps saturate; unmapped writes ignored
        set_walls(WMAX, WMAX, WMAX, WMIN, WMIN, WMIN, 1'b1);
        add_random_bodies(150);
        wait_idle();

        repeat (3)
        begin
            set_random_walls();
            add_random_bodies(150);
            wait_idle();
        end

        // fully open box written explicitly
        set_walls(WMIN, WMIN, WMIN, WMAX, WMAX, WMAX, 1'b1);
        add_random_bodies(100);
        wait_idle();

        $display("%0d bodies sent, %0d results checked, %0d wall settings written",
                 n_sent, n_checked, n_settings);
        $display("%0d mismatches", n_errors);
        if (n_errors == 0 && corrected_bodies.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/sbb_pkg.sv
rtl/sbb_axis_lane.sv
rtl/sbb_spin_damp.sv
rtl/sphere_box_boundary_bounce.sv
tb/testbench.sv
